/* sv/rcpwm_pkg.sv */
`timescale 1ns / 1ps
// rcpwm_pkg: shared constants for the rc pwm channel decoder
// register indexes, reset values and default sizes; no dependencies

package rcpwm_pkg;

  // default sizes
  localparam int NUM_CHANNELS_DEF    = 6;
  localparam int FRAC_BITS_DEF       = 4;
  localparam int DROP_COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int TS_BITS     = 32;
  localparam int CH_BITS     = 3;
  localparam int PCT_BITS    = 7;
  localparam int WEIGHT_BITS = 9;
  localparam int LIMIT_BITS  = 12;
  localparam int FLAG_BITS   = 6;
  localparam int DROP_OUT_BITS = 16;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_MIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_MAX   = 3'd4;

  // reset values of the registers
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST      = 9'd205;
  localparam logic [LIMIT_BITS-1:0]  LOW_LIMIT_RST   = 12'd950;
  localparam logic [LIMIT_BITS-1:0]  HIGH_LIMIT_RST  = 12'd2050;
  localparam logic [LIMIT_BITS-1:0]  INITIAL_MIN_RST = 12'd1500;
  localparam logic [LIMIT_BITS-1:0]  INITIAL_MAX_RST = 12'd1500;

  // full weight is 256/256
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = 9'd256;
  localparam logic [PCT_BITS-1:0]    PCT_FULL    = 7'd100;

  // func codes
  localparam logic FUNC_EDGE  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

endpackage

/* sv/rc_pwm_channel_decoder_unit.sv */
`timescale 1ns / 1ps
// rc_pwm_channel_decoder_unit: six-channel rc pwm pulse width decoder
// depends on rcpwm_pkg; one shared adder under a small sequencer
//
// usage
//   input channel (in_valid/in_ready): func, channel, timestamp. func edge
//   measures the time since that channel's previous edge, filters it and,
//   when it lies inside the limits, maps it to 0..100 percent. func clear
//   zeroes the new flags. exactly one result transaction per input.
//   output channel (out_valid/out_ready): one registered result slot.
//   configuration: apb-style port, registers at byte addresses 0,4,..,16.
// sequence
//   an edge on a valid channel runs from acceptance to out_valid through the
//   timestamp subtraction, the shift-add filter multiply (two 9-bit weights),
//   two evaluate steps, the restoring percent divide and a commit step; an
//   out-of-limit width or a zero span skips the divide. the subtraction,
//   multiply and divide all run through the same adder; in_ready is low
//   meanwhile and rises with out_valid, so a new edge waits for the last commit.
//   a clear command or an unknown channel goes straight to the commit step.
// reset and stall
//   rst (synchronous) restores the config registers, learned limits and counters.
//   while a result waits on out_ready the next item may still be accepted
//   and worked on; it holds at its commit step until the slot frees.

module rc_pwm_channel_decoder_unit #(
  parameter int NUM_CHANNELS    = rcpwm_pkg::NUM_CHANNELS_DEF,
  parameter int FRAC_BITS       = rcpwm_pkg::FRAC_BITS_DEF,
  parameter int DROP_COUNT_BITS = rcpwm_pkg::DROP_COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic [rcpwm_pkg::CH_BITS-1:0]        channel,
  input  logic [rcpwm_pkg::TS_BITS-1:0]        timestamp,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rcpwm_pkg::CH_BITS-1:0]        channel_out,
  output logic [rcpwm_pkg::PCT_BITS-1:0]       percent,
  output logic                                 accepted,
  output logic [rcpwm_pkg::FLAG_BITS-1:0]      new_flags,
  output logic                                 limits_complete,
  output logic [rcpwm_pkg::DROP_OUT_BITS-1:0]  dropped_count,
  output logic                                 span_zero,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rcpwm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rcpwm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rcpwm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int W        = rcpwm_pkg::LIMIT_BITS + FRAC_BITS;
  localparam int ACC_W    = rcpwm_pkg::TS_BITS + FRAC_BITS + rcpwm_pkg::WEIGHT_BITS;
  localparam int FILT_W   = ACC_W - 8;
  localparam int NUM_W    = W + rcpwm_pkg::PCT_BITS;
  localparam int WB       = rcpwm_pkg::WEIGHT_BITS;
  localparam int PB       = rcpwm_pkg::PCT_BITS;
  localparam int LB       = rcpwm_pkg::LIMIT_BITS;
  localparam logic [3:0] MUL_LAST = 4'(WB - 1);
  localparam logic [3:0] DIV_LAST = 4'(PB - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RAW, S_MUL_A, S_MUL_B, S_EVAL, S_PREP, S_DIV, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [WB-1:0] filter_weight;
  logic [LB-1:0] low_limit;
  logic [LB-1:0] high_limit;
  logic [LB-1:0] initial_min;
  logic [LB-1:0] initial_max;

  // per-channel state
  logic [rcpwm_pkg::TS_BITS-1:0] last_time [NUM_CHANNELS];
  logic [W-1:0]                  prev_width [NUM_CHANNELS];
  logic [W-1:0]                  learned_min [NUM_CHANNELS];
  logic [W-1:0]                  learned_max [NUM_CHANNELS];
  logic [PB-1:0]                 chan_pct [NUM_CHANNELS];
  logic [DROP_COUNT_BITS-1:0]    drops [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]       new_mask;
  logic [2*NUM_CHANNELS-1:0]     limit_mask;

  // current transaction
  logic                          op_func;
  logic                          op_ch_ok;
  logic [rcpwm_pkg::CH_BITS-1:0] op_ch;
  logic [CH_IDX_W-1:0]           op_idx;
  logic [rcpwm_pkg::TS_BITS-1:0] op_ts;
  logic [WB-1:0]                 op_wt;
  logic                          op_acc;
  logic                          op_span0;
  logic [W-1:0]                  op_filt;

  // shared unit working registers
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] mcand;
  logic [WB-1:0]    mplier;
  logic [3:0]       step;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [PB-1:0]    quo;

  // shared adder
  logic [ACC_W-1:0] alu_a;
  logic [ACC_W-1:0] alu_b;
  logic             alu_cin;
  logic [ACC_W:0]   alu_sum;

  logic cfg_wr;
  logic [rcpwm_pkg::REG_IDX_W-1:0] cfg_idx;
  logic out_free;

  // evaluation helpers
  logic [FILT_W-1:0] filt;
  logic [W-1:0]      filt_w;
  logic              in_range;
  logic [W-1:0]      cur_min;
  logic [W-1:0]      cur_max;
  logic [W-1:0]      diff;
  logic [NUM_W-1:0]  num;
  logic [PB-1:0]     pct_new;

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[rcpwm_pkg::CFG_ADDR_W-1:2];
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (cfg_idx)
      rcpwm_pkg::REG_FILTER_WEIGHT: prdata = 32'(filter_weight);
      rcpwm_pkg::REG_LOW_LIMIT:     prdata = 32'(low_limit);
      rcpwm_pkg::REG_HIGH_LIMIT:    prdata = 32'(high_limit);
      rcpwm_pkg::REG_INITIAL_MIN:   prdata = 32'(initial_min);
      rcpwm_pkg::REG_INITIAL_MAX:   prdata = 32'(initial_max);
      default:                      prdata = '0;
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state) inside
      S_RAW: begin
        alu_a   = ACC_W'(op_ts);
        alu_b   = ~ACC_W'(last_time[op_idx]);
        alu_cin = 1'b1;
      end
      S_MUL_A, S_MUL_B: begin
        alu_a = acc;
        alu_b = mplier[0] ? mcand : '0;
      end
      S_DIV: begin
        alu_a   = ACC_W'(rem);
        alu_b   = ~ACC_W'(dsh);
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (ACC_W + 1)'(alu_cin);
  end

  // filtered width is the product sum over 256
  always_comb begin
    filt     = acc[ACC_W-1:8];
    filt_w   = filt[W-1:0];
    in_range = (filt > (FILT_W'(low_limit) << FRAC_BITS))
            && (filt < (FILT_W'(high_limit) << FRAC_BITS));
    cur_min  = learned_min[op_idx];
    cur_max  = learned_max[op_idx];
    diff     = op_filt - cur_min;
    num      = (NUM_W'(diff) << 6) + (NUM_W'(diff) << 5) + (NUM_W'(diff) << 2);
    if (op_span0)
      pct_new = '0;
    else if (quo > rcpwm_pkg::PCT_FULL)
      pct_new = rcpwm_pkg::PCT_FULL;
    else
      pct_new = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      filter_weight <= rcpwm_pkg::WEIGHT_RST;
      low_limit     <= rcpwm_pkg::LOW_LIMIT_RST;
      high_limit    <= rcpwm_pkg::HIGH_LIMIT_RST;
      initial_min   <= rcpwm_pkg::INITIAL_MIN_RST;
      initial_max   <= rcpwm_pkg::INITIAL_MAX_RST;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        last_time[c]   <= '0;
        prev_width[c]  <= '0;
        learned_min[c] <= W'(rcpwm_pkg::INITIAL_MIN_RST) << FRAC_BITS;
        learned_max[c] <= W'(rcpwm_pkg::INITIAL_MAX_RST) << FRAC_BITS;
        chan_pct[c]    <= '0;
        drops[c]       <= '0;
      end
      new_mask   <= '0;
      limit_mask <= '0;
    end else begin
      // a commit in the same cycle refills the slot instead
      if (out_valid && out_ready && state != S_DONE)
        out_valid <= 1'b0;

      if (cfg_wr) begin
        unique case (cfg_idx)
          rcpwm_pkg::REG_FILTER_WEIGHT: filter_weight <= pwdata[WB-1:0];
          rcpwm_pkg::REG_LOW_LIMIT:     low_limit     <= pwdata[LB-1:0];
          rcpwm_pkg::REG_HIGH_LIMIT:    high_limit    <= pwdata[LB-1:0];
          rcpwm_pkg::REG_INITIAL_MIN: begin
            initial_min <= pwdata[LB-1:0];
            for (int c = 0; c < NUM_CHANNELS; c++)
              learned_min[c] <= W'(pwdata[LB-1:0]) << FRAC_BITS;
          end
          rcpwm_pkg::REG_INITIAL_MAX: begin
            initial_max <= pwdata[LB-1:0];
            for (int c = 0; c < NUM_CHANNELS; c++)
              learned_max[c] <= W'(pwdata[LB-1:0]) << FRAC_BITS;
          end
          default: begin
            initial_max <= initial_max;
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_func  <= func;
            op_ch    <= channel;
            op_idx   <= CH_IDX_W'(channel);
            op_ts    <= timestamp;
            op_ch_ok <= (int'(channel) < NUM_CHANNELS);
            op_wt    <= (filter_weight > rcpwm_pkg::WEIGHT_FULL) ?
                        rcpwm_pkg::WEIGHT_FULL : filter_weight;
            if (func == rcpwm_pkg::FUNC_CLEAR || int'(channel) >= NUM_CHANNELS)
              state <= S_DONE;
            else
              state <= S_RAW;
          end
        end
        S_RAW: begin
          // raw width wraps modulo 2^32
          mcand  <= ACC_W'(alu_sum[rcpwm_pkg::TS_BITS-1:0]) << FRAC_BITS;
          mplier <= op_wt;
          acc    <= '0;
          step   <= '0;
          state  <= S_MUL_A;
        end
        S_MUL_A: begin
          acc <= alu_sum[ACC_W-1:0];
          if (step == MUL_LAST) begin
            mcand  <= ACC_W'(prev_width[op_idx]);
            mplier <= rcpwm_pkg::WEIGHT_FULL - op_wt;
            step   <= '0;
            state  <= S_MUL_B;
          end else begin
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            step   <= step + 4'd1;
          end
        end
        S_MUL_B: begin
          acc    <= alu_sum[ACC_W-1:0];
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step + 4'd1;
          if (step == MUL_LAST)
            state <= S_EVAL;
        end
        S_EVAL: begin
          op_acc  <= in_range;
          op_filt <= filt_w;
          last_time[op_idx] <= op_ts;
          if (in_range) begin
            if (filt_w < cur_min) begin
              learned_min[op_idx] <= filt_w;
              limit_mask[{op_idx, 1'b0}] <= 1'b1;
            end else if (filt_w > cur_max) begin
              learned_max[op_idx] <= filt_w;
              limit_mask[{op_idx, 1'b1}] <= 1'b1;
            end
            new_mask[op_idx]   <= 1'b1;
            prev_width[op_idx] <= filt_w;
            drops[op_idx]      <= '0;
          end else if (!(&drops[op_idx])) begin
            drops[op_idx] <= drops[op_idx] + DROP_COUNT_BITS'(1);
          end
          state <= S_PREP;
        end
        S_PREP: begin
          op_span0 <= (cur_max <= cur_min);
          rem      <= num;
          dsh      <= NUM_W'(cur_max - cur_min) << (PB - 1);
          quo      <= '0;
          step     <= '0;
          if (op_acc && (cur_max > cur_min))
            state <= S_DIV;
          else
            state <= S_DONE;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (alu_sum[ACC_W])
            rem <= alu_sum[NUM_W-1:0];
          quo  <= {quo[PB-2:0], alu_sum[ACC_W]};
          dsh  <= dsh >> 1;
          step <= step + 4'd1;
          if (step == DIV_LAST)
            state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            limits_complete <= &limit_mask;
            if (op_func == rcpwm_pkg::FUNC_CLEAR) begin
              new_mask      <= '0;
              channel_out   <= '0;
              percent       <= '0;
              accepted      <= 1'b0;
              new_flags     <= '0;
              dropped_count <= '0;
              span_zero     <= 1'b0;
            end else if (!op_ch_ok) begin
              channel_out   <= op_ch;
              percent       <= '0;
              accepted      <= 1'b0;
              new_flags     <= rcpwm_pkg::FLAG_BITS'(new_mask);
              dropped_count <= '0;
              span_zero     <= 1'b0;
            end else begin
              channel_out   <= op_ch;
              accepted      <= op_acc;
              new_flags     <= rcpwm_pkg::FLAG_BITS'(new_mask);
              dropped_count <= rcpwm_pkg::DROP_OUT_BITS'(drops[op_idx]);
              span_zero     <= op_span0;
              if (op_acc) begin
                chan_pct[op_idx] <= pct_new;
                percent          <= pct_new;
              end else begin
                percent <= chan_pct[op_idx];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/rcpwm_checker.sv */
`timescale 1ns / 1ps
// rcpwm_checker: port-level assertions for rc_pwm_channel_decoder_unit
// depends on rcpwm_pkg; bound to the top level below

module rcpwm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rcpwm_pkg::PCT_BITS-1:0]      percent,
  input logic                                accepted,
  input logic                                span_zero
);

  // one transaction in flight: ready drops right after an input is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an input transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(percent) && $stable(accepted)))
    else $error("stalled result changed");

  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (percent <= rcpwm_pkg::PCT_FULL))
    else $error("percent above full scale");

  a_span_zero_pct: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted && span_zero) |-> (percent == '0))
    else $error("zero span but non-zero percent");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rc_pwm_channel_decoder_unit rcpwm_checker u_rcpwm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .percent   (percent),
  .accepted  (accepted),
  .span_zero (span_zero)
);
